[rtl/pts_pkg.sv]
// Shared types, sizes and command codes of the priority thread scheduler.
`default_nettype none
package pts_pkg;

    localparam int THREAD_SLOTS = 8;
    localparam int EVENT_SLOTS  = 4;

    localparam int TAW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int EAW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int LCW = $clog2(THREAD_SLOTS + 1);
    localparam int ECW = $clog2(EVENT_SLOTS + 1);
    localparam int SCAN_MAX = (THREAD_SLOTS > EVENT_SLOTS) ? THREAD_SLOTS : EVENT_SLOTS;
    localparam int CW  = $clog2(SCAN_MAX + 1);

    localparam logic [8:0] NO_PRIO = 9'd256;

    typedef enum logic [3:0] {
        KIND_TICK        = 4'd0,
        KIND_SCHEDULE    = 4'd1,
        KIND_ADD_THREAD  = 4'd2,
        KIND_KILL_ID     = 4'd3,
        KIND_KILL_SELF   = 4'd4,
        KIND_KILL_OTHERS = 4'd5,
        KIND_SLEEP       = 4'd6,
        KIND_ADD_EVENT   = 4'd7,
        KIND_SET_BLOCKED = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_LAST      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [31:0] wake;
        logic [15:0] ident;
    } thr_entry_t;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] due;
    } ev_entry_t;

    function automatic logic [TAW-1:0] next_slot(input logic [TAW-1:0] s);
        return (s == TAW'(THREAD_SLOTS - 1)) ? '0 : s + TAW'(1);
    endfunction

endpackage
`default_nettype wire

[rtl/priority_thread_scheduler_core.sv]
// Thread table and scheduler built around a thread record memory and an event memory.
// Table edits pass through EXEC, FIN_RD and FIN; a kill by ID with more than one live
// thread adds a scan of the thread table, a schedule step adds one thread scan, and a tick
// scans the events and then the thread table twice. Scans read one entry per cycle.
// One transaction at a time: the next is taken in the cycle after the result registers.
// Reset (rst_n low, asynchronous) clears flags, counters and time; memories are not cleared.
`default_nettype none
module priority_thread_scheduler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [3:0]  kind,
    input  wire logic [7:0]  prio_value,
    input  wire logic [15:0] target_id,
    input  wire logic [2:0]  target_slot,
    input  wire logic        block_flag,
    input  wire logic [31:0] sleep_ticks,
    input  wire logic [31:0] event_period,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       status,
    output logic [2:0]       running_slot,
    output logic [15:0]      running_id,
    output logic             idle,
    output logic [3:0]       fired_events,
    output logic [15:0]      new_id,
    output logic [31:0]      now_ticks
);

    localparam int N   = pts_pkg::THREAD_SLOTS;
    localparam int E   = pts_pkg::EVENT_SLOTS;
    localparam int TAW = pts_pkg::TAW;
    localparam int EAW = pts_pkg::EAW;
    localparam int LCW = pts_pkg::LCW;
    localparam int ECW = pts_pkg::ECW;
    localparam int CW  = pts_pkg::CW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_EV, ST_WAKE, ST_PICK, ST_SEL, ST_KILL, ST_FIN_RD, ST_FIN
    } state_t;

    state_t state_reg;

    pts_pkg::kind_t    kind_reg;
    logic [7:0]        prio_reg;
    logic [15:0]       tid_reg;
    logic [2:0]        tslot_reg;
    logic              bflag_reg;
    logic [31:0]       sticks_reg;
    logic [31:0]       period_reg;

    logic [N-1:0]      alive_reg;
    logic [N-1:0]      asleep_reg;
    logic [N-1:0]      blocked_reg;
    logic [TAW-1:0]    cur_reg;
    logic [LCW-1:0]    live_reg;
    logic [15:0]       idc_reg;
    logic [31:0]       time_reg;
    logic [ECW-1:0]    evc_reg;

    logic [CW-1:0]     cnt_reg;
    logic [TAW-1:0]    iss_slot_reg;
    logic              pipe_vld_reg;
    logic [TAW-1:0]    pipe_slot_reg;
    logic [EAW-1:0]    pipe_ev_reg;
    logic [8:0]        best_prio_reg;
    logic [TAW-1:0]    best_slot_reg;
    logic              found_reg;

    pts_pkg::status_t  st_reg;
    logic              idle_flag_reg;
    logic [E-1:0]      fired_reg;
    logic [15:0]       nid_reg;

    logic              res_valid_reg;
    logic [1:0]        status_reg;
    logic [2:0]        run_slot_reg;
    logic [15:0]       run_id_reg;
    logic              idle_reg;
    logic [3:0]        fired_out_reg;
    logic [15:0]       new_id_reg;
    logic [31:0]       now_reg;

    // memories
    pts_pkg::thr_entry_t thr_mem [N];
    pts_pkg::thr_entry_t thr_rd_reg;
    pts_pkg::ev_entry_t  ev_mem [E];
    pts_pkg::ev_entry_t  ev_rd_reg;

    logic [TAW-1:0]      thr_raddr;
    logic                thr_we_full;
    logic                thr_we_wake;
    logic [TAW-1:0]      thr_waddr;
    pts_pkg::thr_entry_t thr_wdata;
    logic [EAW-1:0]      ev_raddr;
    logic                ev_we_full;
    logic                ev_we_due;
    logic [EAW-1:0]      ev_waddr;
    pts_pkg::ev_entry_t  ev_wdata;

    // slot search over the alive flags
    logic [TAW-1:0] free_slot;
    logic [TAW-1:0] first_after;
    logic [TAW-1:0] first_low;
    logic           has_after;
    logic           any_alive;
    logic [TAW-1:0] c_slot;

    logic issue_thr;
    logic issue_ev;
    logic accept;

    assign accept    = item_valid && !item_stall;
    assign issue_thr = (cnt_reg < CW'(N));
    assign issue_ev  = (cnt_reg < CW'(evc_reg));
    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        free_slot   = '0;
        first_after = '0;
        first_low   = '0;
        has_after   = 1'b0;
        any_alive   = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!alive_reg[i])
            begin
                free_slot = TAW'(i);
            end
            if (alive_reg[i])
            begin
                first_low = TAW'(i);
                any_alive = 1'b1;
                if (TAW'(i) > cur_reg)
                begin
                    first_after = TAW'(i);
                    has_after   = 1'b1;
                end
            end
        end
        c_slot = has_after ? first_after : first_low;
    end

    always_comb
    begin
        thr_raddr   = cur_reg;
        thr_we_full = 1'b0;
        thr_we_wake = 1'b0;
        thr_waddr   = cur_reg;
        thr_wdata   = '{prio: prio_reg, wake: sticks_reg + time_reg, ident: idc_reg};
        ev_raddr    = '0;
        ev_we_full  = 1'b0;
        ev_we_due   = 1'b0;
        ev_waddr    = evc_reg[EAW-1:0];
        ev_wdata    = '{period: period_reg,
                        due: period_reg + time_reg + ((evc_reg == '0) ? 32'd0 : 32'd1)};
        case (state_reg)
            ST_EXEC:
            begin
                case (kind_reg)
                    pts_pkg::KIND_ADD_THREAD:
                    begin
                        if (live_reg < LCW'(N))
                        begin
                            thr_we_full    = 1'b1;
                            thr_waddr      = free_slot;
                            thr_wdata.wake = 32'd0;
                        end
                    end
                    pts_pkg::KIND_SLEEP:
                    begin
                        thr_we_wake = 1'b1;
                    end
                    pts_pkg::KIND_ADD_EVENT:
                    begin
                        ev_we_full = (evc_reg < ECW'(E));
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EV:
            begin
                ev_raddr = cnt_reg[EAW-1:0];
                if (pipe_vld_reg && (ev_rd_reg.due == time_reg))
                begin
                    ev_we_due = 1'b1;
                    ev_waddr  = pipe_ev_reg;
                    ev_wdata  = '{period: ev_rd_reg.period,
                                  due: ev_rd_reg.period + time_reg};
                end
            end
            ST_WAKE, ST_SEL, ST_KILL:
            begin
                thr_raddr = iss_slot_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (thr_we_full)
        begin
            thr_mem[thr_waddr] <= thr_wdata;
        end
        else if (thr_we_wake)
        begin
            thr_mem[thr_waddr].wake <= thr_wdata.wake;
        end
        thr_rd_reg <= thr_mem[thr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ev_we_full)
        begin
            ev_mem[ev_waddr] <= ev_wdata;
        end
        else if (ev_we_due)
        begin
            ev_mem[ev_waddr].due <= ev_wdata.due;
        end
        ev_rd_reg <= ev_mem[ev_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alive_reg     <= '0;
            asleep_reg    <= '0;
            blocked_reg   <= '0;
            cur_reg       <= '0;
            live_reg      <= '0;
            idc_reg       <= '0;
            time_reg      <= '0;
            evc_reg       <= '0;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !result_stall && (state_reg != ST_FIN))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg      <= pts_pkg::kind_t'(kind);
                        prio_reg      <= prio_value;
                        tid_reg       <= target_id;
                        tslot_reg     <= target_slot;
                        bflag_reg     <= block_flag;
                        sticks_reg    <= sleep_ticks;
                        period_reg    <= event_period;
                        st_reg        <= pts_pkg::STAT_OK;
                        idle_flag_reg <= 1'b0;
                        fired_reg     <= '0;
                        nid_reg       <= '0;
                        state_reg     <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg    <= (kind_reg == pts_pkg::KIND_TICK) ? ST_EV :
                                    (kind_reg == pts_pkg::KIND_SCHEDULE) ? ST_PICK :
                                    ((kind_reg == pts_pkg::KIND_KILL_ID)
                                     && (live_reg != LCW'(1))) ? ST_KILL : ST_FIN_RD;
                    cnt_reg      <= '0;
                    iss_slot_reg <= '0;
                    pipe_vld_reg <= 1'b0;
                    found_reg    <= 1'b0;
                    case (kind_reg)
                        pts_pkg::KIND_TICK:
                        begin
                            time_reg <= time_reg + 32'd1;
                        end
                        pts_pkg::KIND_ADD_THREAD:
                        begin
                            if (live_reg >= LCW'(N))
                            begin
                                st_reg <= pts_pkg::STAT_FULL;
                            end
                            else
                            begin
                                alive_reg[free_slot]   <= 1'b1;
                                asleep_reg[free_slot]  <= 1'b0;
                                blocked_reg[free_slot] <= 1'b0;
                                nid_reg  <= idc_reg;
                                idc_reg  <= idc_reg + 16'd1;
                                live_reg <= live_reg + LCW'(1);
                            end
                        end
                        pts_pkg::KIND_KILL_ID:
                        begin
                            if (live_reg == LCW'(1))
                            begin
                                st_reg <= pts_pkg::STAT_LAST;
                            end
                        end
                        pts_pkg::KIND_KILL_SELF:
                        begin
                            if (live_reg == LCW'(1))
                            begin
                                st_reg <= pts_pkg::STAT_LAST;
                            end
                            else if (!alive_reg[cur_reg])
                            begin
                                st_reg <= pts_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                alive_reg[cur_reg] <= 1'b0;
                                live_reg <= live_reg - LCW'(1);
                            end
                        end
                        pts_pkg::KIND_KILL_OTHERS:
                        begin
                            if (live_reg == LCW'(1))
                            begin
                                st_reg <= pts_pkg::STAT_LAST;
                            end
                            else if (!alive_reg[cur_reg])
                            begin
                                st_reg <= pts_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                alive_reg <= N'(1) << cur_reg;
                                live_reg  <= LCW'(1);
                            end
                        end
                        pts_pkg::KIND_SLEEP:
                        begin
                            asleep_reg[cur_reg] <= 1'b1;
                        end
                        pts_pkg::KIND_ADD_EVENT:
                        begin
                            if (evc_reg >= ECW'(E))
                            begin
                                st_reg <= pts_pkg::STAT_FULL;
                            end
                            else
                            begin
                                evc_reg <= evc_reg + ECW'(1);
                            end
                        end
                        pts_pkg::KIND_SET_BLOCKED:
                        begin
                            if (32'(tslot_reg) < 32'(N))
                            begin
                                blocked_reg[TAW'(tslot_reg)] <= bflag_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_EV:
                begin
                    if (pipe_vld_reg && (ev_rd_reg.due == time_reg))
                    begin
                        fired_reg[pipe_ev_reg] <= 1'b1;
                    end
                    if (issue_ev)
                    begin
                        pipe_vld_reg <= 1'b1;
                        pipe_ev_reg  <= cnt_reg[EAW-1:0];
                        cnt_reg      <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        pipe_vld_reg <= 1'b0;
                        if (!pipe_vld_reg)
                        begin
                            cnt_reg      <= '0;
                            iss_slot_reg <= '0;
                            state_reg    <= ST_WAKE;
                        end
                    end
                end
                ST_WAKE:
                begin
                    if (pipe_vld_reg && alive_reg[pipe_slot_reg] && asleep_reg[pipe_slot_reg]
                        && (thr_rd_reg.wake < time_reg))
                    begin
                        asleep_reg[pipe_slot_reg] <= 1'b0;
                    end
                    if (issue_thr)
                    begin
                        pipe_vld_reg  <= 1'b1;
                        pipe_slot_reg <= iss_slot_reg;
                        iss_slot_reg  <= pts_pkg::next_slot(iss_slot_reg);
                        cnt_reg       <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        pipe_vld_reg <= 1'b0;
                        if (!pipe_vld_reg)
                        begin
                            state_reg <= ST_PICK;
                        end
                    end
                end
                ST_PICK:
                begin
                    if (!any_alive)
                    begin
                        idle_flag_reg <= 1'b1;
                        state_reg     <= ST_FIN_RD;
                    end
                    else
                    begin
                        cur_reg       <= c_slot;
                        iss_slot_reg  <= pts_pkg::next_slot(c_slot);
                        cnt_reg       <= '0;
                        best_prio_reg <= pts_pkg::NO_PRIO;
                        pipe_vld_reg  <= 1'b0;
                        state_reg     <= ST_SEL;
                    end
                end
                ST_SEL:
                begin
                    // scan from the slot after C round to C, first lowest value wins
                    if (pipe_vld_reg && alive_reg[pipe_slot_reg] && !asleep_reg[pipe_slot_reg]
                        && !blocked_reg[pipe_slot_reg]
                        && ({1'b0, thr_rd_reg.prio} < best_prio_reg))
                    begin
                        best_prio_reg <= {1'b0, thr_rd_reg.prio};
                        best_slot_reg <= pipe_slot_reg;
                    end
                    if (issue_thr)
                    begin
                        pipe_vld_reg  <= 1'b1;
                        pipe_slot_reg <= iss_slot_reg;
                        iss_slot_reg  <= pts_pkg::next_slot(iss_slot_reg);
                        cnt_reg       <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        pipe_vld_reg <= 1'b0;
                        if (!pipe_vld_reg)
                        begin
                            if (best_prio_reg == pts_pkg::NO_PRIO)
                            begin
                                idle_flag_reg <= 1'b1;
                            end
                            else
                            begin
                                cur_reg <= best_slot_reg;
                            end
                            state_reg <= ST_FIN_RD;
                        end
                    end
                end
                ST_KILL:
                begin
                    if (pipe_vld_reg && !found_reg && alive_reg[pipe_slot_reg]
                        && (thr_rd_reg.ident == tid_reg))
                    begin
                        alive_reg[pipe_slot_reg] <= 1'b0;
                        live_reg  <= live_reg - LCW'(1);
                        found_reg <= 1'b1;
                    end
                    if (issue_thr)
                    begin
                        pipe_vld_reg  <= 1'b1;
                        pipe_slot_reg <= iss_slot_reg;
                        iss_slot_reg  <= pts_pkg::next_slot(iss_slot_reg);
                        cnt_reg       <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        pipe_vld_reg <= 1'b0;
                        if (!pipe_vld_reg)
                        begin
                            if (!found_reg)
                            begin
                                st_reg <= pts_pkg::STAT_NOT_FOUND;
                            end
                            state_reg <= ST_FIN_RD;
                        end
                    end
                end
                ST_FIN_RD:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // hold until the output register is free
                    if (!res_valid_reg || !result_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        run_slot_reg  <= 3'(cur_reg);
                        run_id_reg    <= alive_reg[cur_reg] ? thr_rd_reg.ident : 16'd0;
                        idle_reg      <= idle_flag_reg;
                        fired_out_reg <= 4'(fired_reg);
                        new_id_reg    <= nid_reg;
                        now_reg       <= time_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign running_slot = run_slot_reg;
    assign running_id   = run_id_reg;
    assign idle         = idle_reg;
    assign fired_events = fired_out_reg;
    assign new_id       = new_id_reg;
    assign now_ticks    = now_reg;

    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) == $countones(alive_reg))
        else $error("live count does not match alive flags");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_stall)
        else $error("new transaction taken while one is in progress");

    a_event_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(evc_reg) <= 32'(E))
        else $error("event count beyond event slots");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid_reg && $past(rst_n)) |=> (!res_valid_reg || $past(state_reg == ST_FIN)))
        else $error("result raised outside the finish state");

endmodule
`default_nettype wire
